// ===== design/bse_pkg.sv =====
// Shared types, constants and defaults for the burning ship escape iterator.
package bse_pkg;

  // Default parameter values for the top level
  localparam int FRAC_BITS_DEF  = 28;
  localparam int PIX_WIDTH_DEF  = 12;
  localparam int ITER_WIDTH_DEF = 16;

  // Fixed widths of the configuration registers and port
  localparam int CENTER_W   = 32;
  localparam int STEP_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [CENTER_W-1:0] CENTER_RST = '0;
  localparam logic [STEP_W-1:0]   STEP_RST   = 31'd1048576;
  localparam int                  MAXIT_RST  = 50;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 2'd0,
    CFG_CENTER_Y   = 2'd1,
    CFG_PIXEL_STEP = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_MAP_C,
    ST_MUL_XY,
    ST_UPDATE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MOP_PX,
    MOP_PY,
    MOP_XY,
    MOP_XX,
    MOP_YY
  } mul_op_e;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic    start;
    mul_op_e mul_op;
    logic    map_cr_en;
    logic    map_ci_en;
    logic    diff_en;
    logic    upd_en;
    logic    xx_en;
    logic    yy_en;
  } ctl_t;

endpackage

// ===== design/bse_mul.sv =====
// Shared unsigned multiplier with a registered product.
module bse_mul #(
  parameter int MUL_W = 32
) (
  input  logic               clk_i,
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_W-1:0]   b_i,
  output logic [2*MUL_W-1:0] prod_o
);

  logic [2*MUL_W-1:0] prod_q;

  // One product per cycle, result available the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== design/bse_dp.sv =====
// Datapath: point mapping, z update and escape test around the shared multiplier.
module bse_dp #(
  parameter int FRAC_BITS = bse_pkg::FRAC_BITS_DEF,
  parameter int PIX_WIDTH = bse_pkg::PIX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  bse_pkg::ctl_t                 ctl_i,
  input  logic [PIX_WIDTH-1:0]          pix_x_i,
  input  logic [PIX_WIDTH-1:0]          pix_y_i,
  input  logic [bse_pkg::CENTER_W-1:0]  center_x_i,
  input  logic [bse_pkg::CENTER_W-1:0]  center_y_i,
  input  logic [bse_pkg::STEP_W-1:0]    pixel_step_i,
  output logic                          esc_hit_o
);

  localparam int VAL_W  = FRAC_BITS + 4;
  localparam int MUL_W  = (VAL_W > bse_pkg::STEP_W) ? VAL_W : bse_pkg::STEP_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int MAP_W  = PROD_W + 2;
  localparam int UPD_W  = VAL_W + 5;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] THRESH = SUM_W'(1) << (2 * FRAC_BITS + 2);

  logic [PIX_WIDTH-1:0] px_q, py_q;
  logic [VAL_W-1:0]     cr_q, ci_q, x_q, y_q;
  logic [PROD_W-1:0]    xx_q, yy_q, d_q;
  logic [PROD_W-1:0]    prod;
  logic [MUL_W-1:0]     op_a, op_b;
  logic [PIX_WIDTH-1:0] px_mag, py_mag;
  logic [VAL_W-1:0]     ax, ay;
  logic                 map_neg;
  logic [bse_pkg::CENTER_W-1:0] map_cen;
  logic [MAP_W-1:0]     prod_ext, prod_sgn, cen_ext, map_sum;
  logic [UPD_W-1:0]     re_sum, im_sum;
  logic [SUM_W-1:0]     mag_sum;

  // Clamp a wide signed sum into the value range
  function automatic logic [VAL_W-1:0] sat_map(input logic [MAP_W-1:0] s);
    logic fits;
    fits = (s[MAP_W-1:VAL_W-1] == {(MAP_W-VAL_W+1){s[MAP_W-1]}});
    if (fits) return s[VAL_W-1:0];
    return s[MAP_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  function automatic logic [VAL_W-1:0] sat_upd(input logic [UPD_W-1:0] s);
    logic fits;
    fits = (s[UPD_W-1:VAL_W-1] == {(UPD_W-VAL_W+1){s[UPD_W-1]}});
    if (fits) return s[VAL_W-1:0];
    return s[UPD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // Magnitudes of the signed operands
  assign px_mag = px_q[PIX_WIDTH-1] ? (~px_q + 1'b1) : px_q;
  assign py_mag = py_q[PIX_WIDTH-1] ? (~py_q + 1'b1) : py_q;
  assign ax     = x_q[VAL_W-1] ? (~x_q + 1'b1) : x_q;
  assign ay     = y_q[VAL_W-1] ? (~y_q + 1'b1) : y_q;

  // Multiplier operand select
  always_comb begin
    unique case (ctl_i.mul_op)
      bse_pkg::MOP_PX: begin
        op_a = MUL_W'(px_mag);
        op_b = MUL_W'(pixel_step_i);
      end
      bse_pkg::MOP_PY: begin
        op_a = MUL_W'(py_mag);
        op_b = MUL_W'(pixel_step_i);
      end
      bse_pkg::MOP_XY: begin
        op_a = MUL_W'(ax);
        op_b = MUL_W'(ay);
      end
      bse_pkg::MOP_XX: begin
        op_a = MUL_W'(ax);
        op_b = MUL_W'(ax);
      end
      bse_pkg::MOP_YY: begin
        op_a = MUL_W'(ay);
        op_b = MUL_W'(ay);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bse_mul #(
    .MUL_W (MUL_W)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // Point mapping: signed offset times step, plus center
  assign map_neg  = ctl_i.map_cr_en ? px_q[PIX_WIDTH-1] : py_q[PIX_WIDTH-1];
  assign map_cen  = ctl_i.map_cr_en ? center_x_i : center_y_i;
  assign prod_ext = {2'b00, prod};
  assign prod_sgn = map_neg ? (~prod_ext + 1'b1) : prod_ext;
  assign cen_ext  = {{(MAP_W-bse_pkg::CENTER_W){map_cen[bse_pkg::CENTER_W-1]}}, map_cen};
  assign map_sum  = prod_sgn + cen_ext;

  // z update: truncated products plus c
  assign re_sum = {2'b00, d_q[FRAC_BITS +: VAL_W+3]} + {{5{cr_q[VAL_W-1]}}, cr_q};
  assign im_sum = {2'b00, prod[FRAC_BITS-1 +: VAL_W+3]} + {{5{ci_q[VAL_W-1]}}, ci_q};

  // Escape test on exact squares
  assign mag_sum   = {1'b0, xx_q} + {1'b0, prod};
  assign esc_hit_o = (mag_sum > THRESH);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      px_q <= pix_x_i;
      py_q <= pix_y_i;
      x_q  <= '0;
      y_q  <= '0;
      xx_q <= '0;
      yy_q <= '0;
    end
    if (ctl_i.map_cr_en) begin
      cr_q <= sat_map(map_sum);
    end
    if (ctl_i.map_ci_en) begin
      ci_q <= sat_map(map_sum);
    end
    if (ctl_i.diff_en) begin
      d_q <= (yy_q > xx_q) ? (yy_q - xx_q) : (xx_q - yy_q);
    end
    if (ctl_i.upd_en) begin
      x_q <= sat_upd(re_sum);
      y_q <= sat_upd(im_sum);
    end
    if (ctl_i.xx_en) begin
      xx_q <= prod;
    end
    if (ctl_i.yy_en) begin
      yy_q <= prod;
    end
  end

endmodule

// ===== design/bse_ctrl.sv =====
// Sequencer: steps the shared multiplier through mapping and iterations, holds the result.
module bse_ctrl #(
  parameter int ITER_WIDTH = bse_pkg::ITER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [ITER_WIDTH-1:0] max_iter_i,
  input  logic                  esc_hit_i,
  output bse_pkg::ctl_t         ctl_o,
  output logic [ITER_WIDTH-1:0] count_o,
  output logic                  escaped_o
);

  bse_pkg::state_e state_q, state_d;
  logic [ITER_WIDTH-1:0] iter_q, iter_d;
  logic [ITER_WIDTH-1:0] count_q, count_d;
  logic                  esc_q, esc_d;
  logic                  last_iter;

  assign last_iter = (iter_q == (max_iter_i - 1'b1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bse_pkg::ST_IDLE:   if (in_valid_i) state_d = bse_pkg::ST_MAP_X;
      bse_pkg::ST_MAP_X:  state_d = bse_pkg::ST_MAP_Y;
      bse_pkg::ST_MAP_Y:  state_d = bse_pkg::ST_MAP_C;
      bse_pkg::ST_MAP_C: begin
        state_d = (max_iter_i == '0) ? bse_pkg::ST_DONE : bse_pkg::ST_MUL_XY;
      end
      bse_pkg::ST_MUL_XY: state_d = bse_pkg::ST_UPDATE;
      bse_pkg::ST_UPDATE: state_d = bse_pkg::ST_MUL_XX;
      bse_pkg::ST_MUL_XX: state_d = bse_pkg::ST_MUL_YY;
      bse_pkg::ST_MUL_YY: state_d = bse_pkg::ST_CHECK;
      bse_pkg::ST_CHECK: begin
        state_d = (esc_hit_i || last_iter) ? bse_pkg::ST_DONE : bse_pkg::ST_MUL_XY;
      end
      bse_pkg::ST_DONE:   if (out_ready_i) state_d = bse_pkg::ST_IDLE;
      default:            state_d = bse_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and handshake outputs
  always_comb begin
    ctl_o        = '0;
    ctl_o.mul_op = bse_pkg::MOP_XY;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      bse_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctl_o.start = in_valid_i;
      end
      bse_pkg::ST_MAP_X:  ctl_o.mul_op = bse_pkg::MOP_PX;
      bse_pkg::ST_MAP_Y: begin
        ctl_o.mul_op    = bse_pkg::MOP_PY;
        ctl_o.map_cr_en = 1'b1;
      end
      bse_pkg::ST_MAP_C:  ctl_o.map_ci_en = 1'b1;
      bse_pkg::ST_MUL_XY: begin
        ctl_o.mul_op  = bse_pkg::MOP_XY;
        ctl_o.diff_en = 1'b1;
      end
      bse_pkg::ST_UPDATE: ctl_o.upd_en = 1'b1;
      bse_pkg::ST_MUL_XX: ctl_o.mul_op = bse_pkg::MOP_XX;
      bse_pkg::ST_MUL_YY: begin
        ctl_o.mul_op = bse_pkg::MOP_YY;
        ctl_o.xx_en  = 1'b1;
      end
      bse_pkg::ST_CHECK:  ctl_o.yy_en = 1'b1;
      bse_pkg::ST_DONE:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Iteration counter and result
  always_comb begin
    iter_d  = iter_q;
    count_d = count_q;
    esc_d   = esc_q;
    priority if (state_q == bse_pkg::ST_IDLE) begin
      iter_d = '0;
    end else if (state_q == bse_pkg::ST_MAP_C && max_iter_i == '0) begin
      count_d = '0;
      esc_d   = 1'b0;
    end else if (state_q == bse_pkg::ST_CHECK) begin
      if (esc_hit_i) begin
        count_d = iter_q;
        esc_d   = 1'b1;
      end else if (last_iter) begin
        count_d = max_iter_i;
        esc_d   = 1'b0;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end else begin
      iter_d = iter_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bse_pkg::ST_IDLE;
      iter_q  <= '0;
      count_q <= '0;
      esc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      count_q <= count_d;
      esc_q   <= esc_d;
    end
  end

  assign count_o   = count_q;
  assign escaped_o = esc_q;

endmodule

// ===== design/burning_ship_escape_iterator.sv =====
// Top level of the burning ship escape iterator: config registers, sequencer, datapath.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_ready_o    pix_x_i, pix_y_i
//  out      output     out_valid_o / out_ready_i  iteration_count_o, escaped_o
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  An item steps through the mapping states MAP_X, MAP_Y and MAP_C, then through
//  MUL_XY, UPDATE, MUL_XX, MUL_YY and CHECK for each iteration, until the point
//  escapes or the iteration cap is reached (a cap of zero skips the iterations).
//  in_ready_o is high only while no item is held; a result waits in its output
//  register until out_ready_i, and the next item is taken the cycle after.
//  Reset (rst_ni low, asynchronous) idles the sequencer and loads defaults; cfg_ready_o is 1.
module burning_ship_escape_iterator #(
  parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF,
  parameter int PIX_WIDTH  = bse_pkg::PIX_WIDTH_DEF,
  parameter int ITER_WIDTH = bse_pkg::ITER_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [PIX_WIDTH-1:0]           pix_x_i,
  input  logic [PIX_WIDTH-1:0]           pix_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ITER_WIDTH-1:0]          iteration_count_o,
  output logic                           escaped_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [bse_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic [bse_pkg::STEP_W-1:0]   pixel_step_q;
  logic [ITER_WIDTH-1:0]        max_iter_q;
  bse_pkg::ctl_t                ctl;
  logic                         esc_hit;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= bse_pkg::CENTER_RST;
      center_y_q   <= bse_pkg::CENTER_RST;
      pixel_step_q <= bse_pkg::STEP_RST;
      max_iter_q   <= ITER_WIDTH'(bse_pkg::MAXIT_RST);
    end else if (cfg_valid_i) begin
      unique case (bse_pkg::cfg_idx_e'(cfg_index_i))
        bse_pkg::CFG_CENTER_X:   center_x_q   <= cfg_data_i[bse_pkg::CENTER_W-1:0];
        bse_pkg::CFG_CENTER_Y:   center_y_q   <= cfg_data_i[bse_pkg::CENTER_W-1:0];
        bse_pkg::CFG_PIXEL_STEP: pixel_step_q <= cfg_data_i[bse_pkg::STEP_W-1:0];
        bse_pkg::CFG_MAX_ITER:   max_iter_q   <= cfg_data_i[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  bse_ctrl #(
    .ITER_WIDTH (ITER_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .max_iter_i  (max_iter_q),
    .esc_hit_i   (esc_hit),
    .ctl_o       (ctl),
    .count_o     (iteration_count_o),
    .escaped_o   (escaped_o)
  );

  bse_dp #(
    .FRAC_BITS (FRAC_BITS),
    .PIX_WIDTH (PIX_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .pix_x_i      (pix_x_i),
    .pix_y_i      (pix_y_i),
    .center_x_i   (center_x_q),
    .center_y_i   (center_y_q),
    .pixel_step_i (pixel_step_q),
    .esc_hit_o    (esc_hit)
  );

endmodule
